FILE: sv/dhoat_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dhoat_pkg
// shared codes, widths and constants of the double hash table
// ============================================================================
package dhoat_pkg;

    // command codes
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_PRESENT = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_MISSING = 2'd3;

    // slot states
    typedef logic [1:0] t_slot_state;
    localparam t_slot_state SLOT_EMPTY   = 2'd0;
    localparam t_slot_state SLOT_LIVE    = 2'd1;
    localparam t_slot_state SLOT_VACATED = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_W = 9;
    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_TOLERANCE  = 1'b1;

    // stream widths
    localparam int unsigned IN_W  = 144;
    localparam int unsigned OUT_W = 96;

    // modulo unit: dividend width and bits retired per cycle
    localparam int unsigned MOD_XW    = 32;
    localparam int unsigned MOD_DIGIT = 4;

    // floor(x/5) as (x * LIM_RECIP) >> LIM_SHIFT for x below 2^19
    localparam int unsigned LIM_SHIFT = 22;
    localparam int unsigned LIM_RECIP = (1 << LIM_SHIFT) / 5 + 1;

endpackage

FILE: sv/dhoat_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// dhoat_ram
// simple dual port ram, one write and one registered read port
// ============================================================================
module dhoat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/dhoat_mod.sv
`timescale 1ns / 1ps
// ============================================================================
// dhoat_mod
// restoring modulo unit, a few dividend bits per cycle
// ============================================================================
module dhoat_mod #(
    parameter int MW = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dhoat_pkg::MOD_XW-1:0] i_x,
    input  logic [MW-1:0]                i_m,
    output logic                         o_busy,
    output logic [MW-1:0]                o_rem
);

    localparam int XW    = dhoat_pkg::MOD_XW;
    localparam int DG    = dhoat_pkg::MOD_DIGIT;
    localparam int STEPS = XW / DG;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [XW-1:0] r_x;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_m;

    logic [XW-1:0] w_x;
    logic [MW-1:0] w_rem;
    logic [MW:0]   w_t;

    // shift in one dividend bit at a time, subtract when the divisor fits
    always_comb begin
        w_x   = r_x;
        w_rem = r_rem;
        w_t   = '0;
        for (int k = 0; k < DG; k++) begin
            w_t = {w_rem, w_x[XW-1]};
            if (w_t >= {1'b0, r_m}) begin
                w_t = w_t - {1'b0, r_m};
            end
            w_rem = w_t[MW-1:0];
            w_x   = {w_x[XW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_rem <= '0;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_x   <= w_x;
            r_rem <= w_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

FILE: sv/double_hash_open_address_table.sv
`timescale 1ns / 1ps
// ============================================================================
// double_hash_open_address_table
// key/value table with open addressing and double hashing
// ============================================================================
// usage:
//   commands enter on the s_axis stream, one result per command leaves on
//   m_axis. table_size and tolerance are set through the cfg write port,
//   by the user only while the block is idle; the block does not enforce it.
//   insert, remove and lookup first reduce both hashes and 2^32 - 1 modulo
//   the table size in three modulo units running side by side, then walk
//   the probe sequence at one slot per cycle through the slot state and key
//   memories. clear sweeps the slot state memory; after reset the same
//   sweep runs before the first command is taken; config writes are taken
//   during it.
//   one command is in flight at a time; the result sits in an output
//   register, so a new command is taken while it waits. a stalled receiver
//   holds the next finished result back until the register is free.
// ============================================================================
module double_hash_open_address_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [dhoat_pkg::CFG_W-1:0]   i_cfg_data,
    // command stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // command, key, value, hash_first, hash_second, position, zero pad
    input  logic [dhoat_pkg::IN_W-1:0]    s_axis_tdata,
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, slot_index, key_out, value_out, entry_total, conflict_total, pad
    output logic [dhoat_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int SW  = AW + 1;
    localparam int KB  = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int KVW = KB + 32;
    localparam int PW  = SW + 2 + 20;

    // fsm codes
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_INIT  = 4'd3;
    localparam logic [3:0] S_PROBE = 4'd4;
    localparam logic [3:0] S_RMN   = 4'd5;
    localparam logic [3:0] S_RMW   = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_RA1   = 4'd8;
    localparam logic [3:0] S_RA2   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    // input fields
    logic [2:0]  w_in_cmd;
    logic [31:0] w_in_key;
    logic [31:0] w_in_val;
    logic [31:0] w_in_h1;
    logic [31:0] w_in_h2;
    logic [7:0]  w_in_pos;
    logic        w_in_acc;

    assign w_in_cmd = s_axis_tdata[2:0];
    assign w_in_key = s_axis_tdata[34:3];
    assign w_in_val = s_axis_tdata[66:35];
    assign w_in_h1  = s_axis_tdata[98:67];
    assign w_in_h2  = s_axis_tdata[130:99];
    assign w_in_pos = s_axis_tdata[138:131];

    // config registers
    logic [dhoat_pkg::CFG_W-1:0] r_table_size;
    logic [dhoat_pkg::CFG_W-1:0] r_tolerance;

    // control registers
    logic [3:0]    r_state,   n_state;
    logic [AW-1:0] r_clr,     n_clr;
    logic          r_clr_cmd, n_clr_cmd;
    logic [SW-1:0] r_ec,      n_ec;
    logic [SW-1:0] r_cc,      n_cc;
    logic          r_ovalid,  n_ovalid;

    // payload registers
    logic [2:0]    r_cmd,     n_cmd;
    logic [KB-1:0] r_key,     n_key;
    logic [31:0]   r_val,     n_val;
    logic [31:0]   r_h,       n_h;
    logic [31:0]   r_h2,      n_h2;
    logic [AW-1:0] r_slot,    n_slot;
    logic [SW-1:0] r_i,       n_i;
    logic          r_have_free, n_have_free;
    logic [AW-1:0] r_free,    n_free;
    logic          r_passed,  n_passed;
    logic [AW-1:0] r_hit,     n_hit;
    logic          r_adj,     n_adj;
    logic          r_nextok,  n_nextok;
    logic [SW-1:0] r_lim80;
    logic [1:0]    r_res_status, n_res_status;
    logic [AW-1:0] r_res_slot,   n_res_slot;
    logic [31:0]   r_res_key,    n_res_key;
    logic [31:0]   r_res_val,    n_res_val;
    logic [1:0]    r_o_status,   n_o_status;
    logic [7:0]    r_o_slot,     n_o_slot;
    logic [31:0]   r_o_key,      n_o_key;
    logic [31:0]   r_o_val,      n_o_val;
    logic [8:0]    r_o_ent,      n_o_ent;
    logic [8:0]    r_o_conf,     n_o_conf;

    // memory ports
    logic                   st_we;
    logic [AW-1:0]          st_waddr;
    dhoat_pkg::t_slot_state st_wdata;
    dhoat_pkg::t_slot_state st_rdata;
    logic                   kv_we;
    logic [AW-1:0]          kv_waddr;
    logic [KVW-1:0]         kv_wdata;
    logic [KVW-1:0]         kv_rdata;
    logic                   pos_we;
    logic [AW-1:0]          pos_waddr;
    logic [AW-1:0]          pos_wdata;
    logic [AW-1:0]          pos_rdata;
    logic                   list_we;
    logic [AW-1:0]          list_waddr;
    logic [AW-1:0]          list_wdata;
    logic [AW-1:0]          list_raddr;
    logic [AW-1:0]          list_rdata;

    // effective table size: zero acts as one, clipped to the depth
    logic [SW-1:0] w_size;
    always_comb begin
        if (r_table_size == '0) begin
            w_size = SW'(1);
        end else if (32'(r_table_size) > 32'(TABLE_DEPTH)) begin
            w_size = SW'(TABLE_DEPTH);
        end else begin
            w_size = SW'(r_table_size);
        end
    end

    // entry limit: tol if < size, else floor(size*4/5), reciprocal, registered
    logic [PW-1:0] w_lim_prod;
    logic [SW-1:0] w_limit;
    assign w_lim_prod = PW'({w_size, 2'b00}) * PW'(dhoat_pkg::LIM_RECIP);
    assign w_limit    = (32'(r_tolerance) >= 32'(w_size)) ? r_lim80 : SW'(r_tolerance);

    // modulo units: home slot, stride and 2^32 - 1 modulo the size
    logic          w_mod_start;
    logic [2:0]    w_mod_busy;
    logic [SW-1:0] w_rem1;
    logic [SW-1:0] w_rem2;
    logic [SW-1:0] w_rem3;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_mod_start = w_in_acc && (w_in_cmd inside {dhoat_pkg::CMD_INSERT,
                         dhoat_pkg::CMD_REMOVE, dhoat_pkg::CMD_LOOKUP});

    dhoat_mod #(.MW(SW)) u_mod_home (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start), .i_x(w_in_h1),
        .i_m(w_size), .o_busy(w_mod_busy[0]), .o_rem(w_rem1)
    );
    dhoat_mod #(.MW(SW)) u_mod_stride (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start), .i_x(w_in_h2),
        .i_m(w_size), .o_busy(w_mod_busy[1]), .o_rem(w_rem2)
    );
    dhoat_mod #(.MW(SW)) u_mod_wrap (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start), .i_x(32'hFFFF_FFFF),
        .i_m(w_size), .o_busy(w_mod_busy[2]), .o_rem(w_rem3)
    );

    // next probe slot: add the stride, take back 2^32 mod size on wrap
    logic [32:0]   w_hsum;
    logic [SW-1:0] w_wrap;
    logic [SW:0]   w_t1;
    logic [SW-1:0] w_t2;
    logic [AW-1:0] w_step_slot;

    always_comb begin
        w_hsum = {1'b0, r_h} + {1'b0, r_h2};
        w_wrap = (w_rem3 + SW'(1) == w_size) ? '0 : (w_rem3 + SW'(1));
        w_t1   = (SW+1)'(r_slot) + (SW+1)'(w_rem2);
        if (w_t1 >= (SW+1)'(w_size)) begin
            w_t1 = w_t1 - (SW+1)'(w_size);
        end
        w_t2 = SW'(w_t1);
        if (w_hsum[32]) begin
            if (w_t2 >= w_wrap) begin
                w_t2 = w_t2 - w_wrap;
            end else begin
                w_t2 = w_t2 + w_size - w_wrap;
            end
        end
        w_step_slot = AW'(w_t2);
    end

    // probe decode
    logic [KB-1:0] w_mkey;
    logic [31:0]   w_mval;
    logic          w_last;
    logic          w_is_free;
    logic          w_match;
    logic [SW-1:0] w_ec_dec;

    assign w_mkey    = kv_rdata[KVW-1:32];
    assign w_mval    = kv_rdata[31:0];
    assign w_last    = (r_i == w_size - SW'(1));
    assign w_is_free = (st_rdata == dhoat_pkg::SLOT_EMPTY) ||
                       (st_rdata == dhoat_pkg::SLOT_VACATED);
    assign w_match   = (st_rdata == dhoat_pkg::SLOT_LIVE) && (w_mkey == r_key);
    assign w_ec_dec  = r_ec - SW'(1);

    assign list_raddr = (r_state == S_IDLE) ? AW'(w_in_pos) : AW'(w_ec_dec);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_clr_cmd    = r_clr_cmd;
        n_ec         = r_ec;
        n_cc         = r_cc;
        n_ovalid     = r_ovalid && !m_axis_tready;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_h          = r_h;
        n_h2         = r_h2;
        n_slot       = r_slot;
        n_i          = r_i;
        n_have_free  = r_have_free;
        n_free       = r_free;
        n_passed     = r_passed;
        n_hit        = r_hit;
        n_adj        = r_adj;
        n_nextok     = r_nextok;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_key    = r_res_key;
        n_res_val    = r_res_val;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;
        n_o_key      = r_o_key;
        n_o_val      = r_o_val;
        n_o_ent      = r_o_ent;
        n_o_conf     = r_o_conf;
        st_we        = 1'b0;
        st_waddr     = r_hit;
        st_wdata     = dhoat_pkg::SLOT_VACATED;
        kv_we        = 1'b0;
        kv_waddr     = r_free;
        kv_wdata     = {r_key, r_val};
        pos_we       = 1'b0;
        pos_waddr    = r_free;
        pos_wdata    = AW'(r_ec);
        list_we      = 1'b0;
        list_waddr   = AW'(r_ec);
        list_wdata   = r_free;

        case (r_state)
            // sweep every slot to empty
            S_CLR: begin
                st_we    = 1'b1;
                st_waddr = r_clr;
                st_wdata = dhoat_pkg::SLOT_EMPTY;
                n_clr    = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_clr   = '0;
                    n_state = r_clr_cmd ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd        = w_in_cmd;
                    n_key        = w_in_key[KB-1:0];
                    n_val        = w_in_val;
                    n_h          = w_in_h1;
                    n_h2         = w_in_h2;
                    n_res_status = dhoat_pkg::STAT_OK;
                    n_res_slot   = '0;
                    n_res_key    = '0;
                    n_res_val    = '0;
                    case (w_in_cmd)
                        dhoat_pkg::CMD_INSERT,
                        dhoat_pkg::CMD_REMOVE,
                        dhoat_pkg::CMD_LOOKUP: begin
                            n_state = S_MOD;
                        end
                        dhoat_pkg::CMD_READ: begin
                            if (32'(w_in_pos) >= 32'(r_ec)) begin
                                n_res_status = dhoat_pkg::STAT_MISSING;
                                n_state      = S_OUT;
                            end else begin
                                n_state = S_RA1;
                            end
                        end
                        dhoat_pkg::CMD_CLEAR: begin
                            n_ec      = '0;
                            n_cc      = '0;
                            n_clr     = '0;
                            n_clr_cmd = 1'b1;
                            n_state   = S_CLR;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (w_mod_busy == '0) begin
                    n_state = S_INIT;
                end
            end
            // early refusals, else start the walk at the home slot
            S_INIT: begin
                if (r_cmd == dhoat_pkg::CMD_INSERT && r_ec >= w_limit) begin
                    n_res_status = dhoat_pkg::STAT_FULL;
                    n_state      = S_OUT;
                end else if (r_cmd == dhoat_pkg::CMD_REMOVE && r_ec == '0) begin
                    n_res_status = dhoat_pkg::STAT_MISSING;
                    n_state      = S_OUT;
                end else begin
                    n_slot      = AW'(w_rem1);
                    n_i         = '0;
                    n_have_free = 1'b0;
                    n_passed    = 1'b0;
                    n_state     = S_PROBE;
                end
            end
            // one slot a cycle, memory data belongs to r_slot
            S_PROBE: begin
                if (w_is_free && !r_have_free) begin
                    n_have_free = 1'b1;
                    n_free      = r_slot;
                end
                if (w_match) begin
                    n_res_slot = r_slot;
                    n_res_key  = 32'(w_mkey);
                    n_res_val  = w_mval;
                    case (r_cmd)
                        dhoat_pkg::CMD_INSERT: begin
                            n_res_status = dhoat_pkg::STAT_PRESENT;
                            n_state      = S_OUT;
                        end
                        dhoat_pkg::CMD_REMOVE: begin
                            n_hit    = r_slot;
                            n_adj    = r_passed;
                            n_nextok = !w_last;
                            n_slot   = w_step_slot;
                            n_state  = S_RMN;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end else if (st_rdata == dhoat_pkg::SLOT_EMPTY || w_last) begin
                    // search ends without a match
                    if (r_cmd == dhoat_pkg::CMD_INSERT) begin
                        if ((r_have_free || w_is_free) && r_ec < SW'(TABLE_DEPTH)) begin
                            n_state = S_INS;
                        end else begin
                            n_res_status = dhoat_pkg::STAT_FULL;
                            n_state      = S_OUT;
                        end
                    end else begin
                        n_res_status = dhoat_pkg::STAT_MISSING;
                        n_state      = S_OUT;
                    end
                end else begin
                    if (st_rdata != dhoat_pkg::SLOT_VACATED) begin
                        n_passed = 1'b1;
                    end
                    n_h    = w_hsum[31:0];
                    n_slot = w_step_slot;
                    n_i    = r_i + SW'(1);
                end
            end
            // state of the slot after the match
            S_RMN: begin
                n_adj   = r_adj || (r_nextok && st_rdata != dhoat_pkg::SLOT_EMPTY);
                n_state = S_RMW;
            end
            // vacate, move the last active entry into the freed position
            S_RMW: begin
                st_we    = 1'b1;
                st_waddr = r_hit;
                st_wdata = dhoat_pkg::SLOT_VACATED;
                n_ec     = w_ec_dec;
                if (SW'(pos_rdata) < w_ec_dec) begin
                    list_we    = 1'b1;
                    list_waddr = pos_rdata;
                    list_wdata = list_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = list_rdata;
                    pos_wdata  = pos_rdata;
                end
                if (r_adj && r_cc != '0) begin
                    n_cc = r_cc - SW'(1);
                end
                n_state = S_OUT;
            end
            S_INS: begin
                st_we      = 1'b1;
                st_waddr   = r_free;
                st_wdata   = dhoat_pkg::SLOT_LIVE;
                kv_we      = 1'b1;
                pos_we     = 1'b1;
                list_we    = 1'b1;
                n_ec       = r_ec + SW'(1);
                if (r_free != AW'(w_rem1) && r_cc < SW'(TABLE_DEPTH)) begin
                    n_cc = r_cc + SW'(1);
                end
                n_res_slot = r_free;
                n_state    = S_OUT;
            end
            S_RA1: begin
                n_slot  = list_rdata;
                n_state = S_RA2;
            end
            S_RA2: begin
                n_res_slot = r_slot;
                n_res_key  = 32'(w_mkey);
                n_res_val  = w_mval;
                n_state    = S_OUT;
            end
            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = 8'(r_res_slot);
                    n_o_key    = r_res_key;
                    n_o_val    = r_res_val;
                    n_o_ent    = 9'(r_ec);
                    n_o_conf   = 9'(r_cc);
                    n_clr_cmd  = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 9'd256;
            r_tolerance  <= 9'd204;
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_clr_cmd    <= 1'b0;
            r_ec         <= '0;
            r_cc         <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    dhoat_pkg::CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                    dhoat_pkg::CFG_TOLERANCE:  r_tolerance  <= i_cfg_data;
                    default: ;
                endcase
            end
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_cmd <= n_clr_cmd;
            r_ec      <= n_ec;
            r_cc      <= n_cc;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_h          <= n_h;
        r_h2         <= n_h2;
        r_slot       <= n_slot;
        r_i          <= n_i;
        r_have_free  <= n_have_free;
        r_free       <= n_free;
        r_passed     <= n_passed;
        r_hit        <= n_hit;
        r_adj        <= n_adj;
        r_nextok     <= n_nextok;
        r_lim80      <= SW'(w_lim_prod >> dhoat_pkg::LIM_SHIFT);
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_key    <= n_res_key;
        r_res_val    <= n_res_val;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        r_o_key      <= n_o_key;
        r_o_val      <= n_o_val;
        r_o_ent      <= n_o_ent;
        r_o_conf     <= n_o_conf;
    end

    // slot state, read at the next probe slot
    dhoat_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_ram_state (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(n_slot), .o_rdata(st_rdata)
    );
    // key and value per slot
    dhoat_ram #(.WIDTH(KVW), .DEPTH(TABLE_DEPTH)) u_ram_kv (
        .i_clk(i_clk), .i_we(kv_we), .i_waddr(kv_waddr), .i_wdata(kv_wdata),
        .i_raddr(n_slot), .o_rdata(kv_rdata)
    );
    // active list position per slot
    dhoat_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_ram_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(r_hit), .o_rdata(pos_rdata)
    );
    // dense active list of live slots
    dhoat_ram #(.WIDTH(AW), .DEPTH(TABLE_DEPTH)) u_ram_list (
        .i_clk(i_clk), .i_we(list_we), .i_waddr(list_waddr), .i_wdata(list_wdata),
        .i_raddr(list_raddr), .o_rdata(list_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_o_conf, r_o_ent, r_o_val, r_o_key,
                            r_o_slot, r_o_status};

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// testbench of the double hash open address table
// ============================================================================
// A scoreboard object keeps its own copy of the table and works out the
// expected result of every accepted command. The monitor checks each result
// field by field against the oldest expected result.
// The run starts with a short directed part: duplicate keys, a full table,
// a probe that finds no free slot, clear, unused codes and edge values.
// Random phases follow. Each phase first sets the table size and the
// tolerance, then sends commands. Most commands use a small pool of keys with
// fixed hashes, so inserts, removes and lookups hit the same chains. The
// remaining commands carry random fields. Sender idling and receiver stalls
// change from phase to phase.
// ============================================================================
module tb_top;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         POOL_N          = 48;
    localparam int         SETTLE_CYCLES   = 300;
    localparam int         CYCLE_LIMIT     = 3000000;

    // reference copy of the table, also used as the scoreboard
    class table_scoreboard;
        dhoat_pkg::t_slot_state slot_st[256];
        logic [31:0]    slot_k[256];
        logic [31:0]    slot_v[256];
        int unsigned    slot_pos[256];
        int unsigned    active[256];
        int unsigned    live_cnt;
        int unsigned    conf_cnt;
        int unsigned    size_reg;
        int unsigned    tol_reg;
        logic [95:0]    expected_q[$];
        int             errors;

        function new();
            for (int s = 0; s < 256; s++) begin
                slot_st[s] = dhoat_pkg::SLOT_EMPTY;
            end
            live_cnt = 0;
            conf_cnt = 0;
            size_reg = 256;
            tol_reg  = 204;
            errors   = 0;
        endfunction

        function void set_reg(logic idx, int unsigned val);
            if (idx == dhoat_pkg::CFG_TABLE_SIZE) begin
                size_reg = val;
            end else begin
                tol_reg = val;
            end
        endfunction

        function int unsigned cur_size();
            if (size_reg == 0) return 1;
            if (size_reg > 256) return 256;
            return size_reg;
        endfunction

        function int unsigned limit();
            if (tol_reg >= cur_size()) return (cur_size() * 4) / 5;
            return tol_reg;
        endfunction

        function int unsigned slot_at(logic [31:0] h1, logic [31:0] h2, int unsigned i);
            logic [31:0] h;
            h = h1 + i * h2;
            return h % cur_size();
        endfunction

        // probe for a live key; first free slot seen goes out as well
        function bit find_key(logic [31:0] key, logic [31:0] h1, logic [31:0] h2,
                              output int unsigned hit, output int unsigned free_s,
                              output bit has_free);
            int unsigned s;
            has_free = 0;
            free_s   = 0;
            hit      = 0;
            for (int unsigned i = 0; i < cur_size(); i++) begin
                s = slot_at(h1, h2, i);
                if (slot_st[s] == dhoat_pkg::SLOT_EMPTY) begin
                    if (!has_free) begin
                        free_s   = s;
                        has_free = 1;
                    end
                    return 0;
                end
                if (slot_st[s] == dhoat_pkg::SLOT_VACATED) begin
                    if (!has_free) begin
                        free_s   = s;
                        has_free = 1;
                    end
                end else if (slot_k[s] == key) begin
                    hit = s;
                    return 1;
                end
            end
            return 0;
        endfunction

        function int unsigned live_count();
            return live_cnt;
        endfunction

        // an accepted command: update the copy, queue the expected result
        function void note_command(logic [2:0] cmd, logic [31:0] key, logic [31:0] val,
                                   logic [31:0] h1, logic [31:0] h2, logic [7:0] pos);
            logic [1:0]  status;
            int unsigned slot;
            logic [31:0] kout;
            logic [31:0] vout;
            int unsigned hit;
            int unsigned fs;
            int unsigned s;
            int unsigned n;
            int unsigned p;
            int unsigned last;
            bit          has_free;
            bit          passed_live;
            bit          adjust;
            status = dhoat_pkg::STAT_OK;
            slot   = 0;
            kout   = '0;
            vout   = '0;
            case (cmd)
                dhoat_pkg::CMD_INSERT: begin
                    if (live_cnt >= limit()) begin
                        status = dhoat_pkg::STAT_FULL;
                    end else if (find_key(key, h1, h2, hit, fs, has_free)) begin
                        status = dhoat_pkg::STAT_PRESENT;
                        slot   = hit;
                        kout   = slot_k[hit];
                        vout   = slot_v[hit];
                    end else if (!has_free || live_cnt >= 256) begin
                        status = dhoat_pkg::STAT_FULL;
                    end else begin
                        slot_st[fs]  = dhoat_pkg::SLOT_LIVE;
                        slot_k[fs]   = key;
                        slot_v[fs]   = val;
                        active[live_cnt] = fs;
                        slot_pos[fs] = live_cnt;
                        live_cnt++;
                        if (fs != h1 % cur_size() && conf_cnt < 256) conf_cnt++;
                        slot = fs;
                    end
                end
                dhoat_pkg::CMD_REMOVE: begin
                    status      = dhoat_pkg::STAT_MISSING;
                    passed_live = 0;
                    if (live_cnt != 0) begin
                        for (int unsigned i = 0; i < cur_size(); i++) begin
                            s = slot_at(h1, h2, i);
                            if (slot_st[s] == dhoat_pkg::SLOT_EMPTY) break;
                            if (slot_st[s] == dhoat_pkg::SLOT_LIVE) begin
                                if (slot_k[s] == key) begin
                                    adjust     = passed_live;
                                    status     = dhoat_pkg::STAT_OK;
                                    slot_st[s] = dhoat_pkg::SLOT_VACATED;
                                    live_cnt--;
                                    p = slot_pos[s];
                                    // last active entry fills the hole
                                    if (p < live_cnt) begin
                                        last          = active[live_cnt] % 256;
                                        active[p]     = last;
                                        slot_pos[last] = p;
                                    end
                                    if (i + 1 < cur_size()) begin
                                        n = slot_at(h1, h2, i + 1);
                                        if (slot_st[n] != dhoat_pkg::SLOT_EMPTY) adjust = 1;
                                    end
                                    if (adjust && conf_cnt > 0) conf_cnt--;
                                    slot = s;
                                    kout = slot_k[s];
                                    vout = slot_v[s];
                                    break;
                                end
                                passed_live = 1;
                            end
                        end
                    end
                end
                dhoat_pkg::CMD_LOOKUP: begin
                    if (find_key(key, h1, h2, hit, fs, has_free)) begin
                        slot = hit;
                        kout = slot_k[hit];
                        vout = slot_v[hit];
                    end else begin
                        status = dhoat_pkg::STAT_MISSING;
                    end
                end
                dhoat_pkg::CMD_READ: begin
                    if (pos < live_cnt) begin
                        slot = active[pos] % 256;
                        kout = slot_k[slot];
                        vout = slot_v[slot];
                    end else begin
                        status = dhoat_pkg::STAT_MISSING;
                    end
                end
                dhoat_pkg::CMD_CLEAR: begin
                    for (int k = 0; k < 256; k++) begin
                        slot_st[k] = dhoat_pkg::SLOT_EMPTY;
                    end
                    live_cnt = 0;
                    conf_cnt = 0;
                end
                default: ;
            endcase
            expected_q.push_back({4'b0, conf_cnt[8:0], live_cnt[8:0], vout, kout,
                                  slot[7:0], status});
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: mismatch in %s, expected %h, actual %h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // a result transfer: compare with the oldest expected result
        function void check_result(logic [95:0] got);
            logic [95:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp_field("status", 32'(want[1:0]), 32'(got[1:0]));
            cmp_field("slot_index", 32'(want[9:2]), 32'(got[9:2]));
            cmp_field("key_out", want[41:10], got[41:10]);
            cmp_field("value_out", want[73:42], got[73:42]);
            cmp_field("entry_total", 32'(want[82:74]), 32'(got[82:74]));
            cmp_field("conflict_total", 32'(want[91:83]), 32'(got[91:83]));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic                            i_cfg_index;
    logic [dhoat_pkg::CFG_W-1:0]     i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [dhoat_pkg::IN_W-1:0]      s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [dhoat_pkg::OUT_W-1:0]     m_axis_tdata;

    table_scoreboard      sb;
    int unsigned          cycle_cnt;
    int unsigned          idle_pct;
    int unsigned          stall_pct;
    logic [31:0]          pool_key[POOL_N];
    logic [31:0]          pool_h1[POOL_N];
    logic [31:0]          pool_h2[POOL_N];

    double_hash_open_address_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls, picked at the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // one command transfer, with random sender idling before it
    task automatic send_cmd(logic [2:0] cmd, logic [31:0] key, logic [31:0] val,
                            logic [31:0] h1, logic [31:0] h2, logic [7:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, pos, h2, h1, val, key, cmd};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_command(cmd, key, val, h1, h2, pos);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait until every expected result has come
    task automatic wait_drained();
        while (sb.expected_q.size() != 0) @(negedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_cfg(logic idx, int unsigned val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val[dhoat_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_reg(idx, 32'(val[dhoat_pkg::CFG_W-1:0]));
    endtask

    // pool command with random fields where they do not matter
    task automatic send_pool(logic [2:0] cmd, int k);
        send_cmd(cmd, pool_key[k], $urandom, pool_h1[k], pool_h2[k],
                 8'($urandom_range(sb.live_count() + 2 > 255 ? 255 : sb.live_count() + 2)));
    endtask

    task automatic random_phase(int n_items, int unsigned size_hint);
        int unsigned pick;
        int          k;
        // fresh pool, strides sometimes sharing factors with the size
        for (int j = 0; j < POOL_N; j++) begin
            pool_key[j] = ($urandom_range(9) == 0) ? $urandom : $urandom_range(63);
            pool_h1[j]  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3 * size_hint);
            case ($urandom_range(3))
                0: pool_h2[j] = $urandom;
                1: pool_h2[j] = 0;
                2: pool_h2[j] = size_hint * $urandom_range(3);
                default: pool_h2[j] = $urandom_range(5);
            endcase
        end
        for (int j = 0; j < n_items; j++) begin
            k    = $urandom_range(POOL_N - 1);
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_pool(dhoat_pkg::CMD_INSERT, k);
            end else if (pick < 60) begin
                send_pool(dhoat_pkg::CMD_REMOVE, k);
            end else if (pick < 78) begin
                send_pool(dhoat_pkg::CMD_LOOKUP, k);
            end else if (pick < 88) begin
                send_pool(dhoat_pkg::CMD_READ, k);
            end else if (pick < 89) begin
                send_pool(dhoat_pkg::CMD_CLEAR, k);
            end else if (pick < 91) begin
                send_pool(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), k);
            end else begin
                // noise: every field random
                send_cmd(3'($urandom_range(CMD_SPARE_LAST)), $urandom, $urandom,
                         $urandom, $urandom, 8'($urandom));
            end
        end
    endtask

    initial begin
        int unsigned sizes[10];
        int unsigned tol;
        sb = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = dhoat_pkg::CFG_TABLE_SIZE;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        idle_pct      = 0;
        stall_pct     = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part with the reset settings
        send_cmd(dhoat_pkg::CMD_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h0);
        send_cmd(dhoat_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 8'hFF);
        send_cmd(dhoat_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h1234, 32'h0, 32'h1, 8'h0);
        send_cmd(dhoat_pkg::CMD_INSERT, 32'h55, 32'h77, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0);
        // stride zero: only the home slot, already taken
        send_cmd(dhoat_pkg::CMD_INSERT, 32'h66, 32'h1, 32'h0, 32'h0, 8'h0);
        send_cmd(dhoat_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1, 8'h0);
        send_cmd(dhoat_pkg::CMD_LOOKUP, 32'h99, 32'h0, 32'h7, 32'h3, 8'h0);
        send_cmd(dhoat_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 8'd2);
        send_cmd(dhoat_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 8'd255);
        send_cmd(dhoat_pkg::CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 8'h0);
        send_cmd(dhoat_pkg::CMD_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 8'h0);
        send_cmd(dhoat_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 8'd0);
        send_cmd(CMD_SPARE_FIRST, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0, 8'hAA);
        send_cmd(CMD_SPARE_LAST, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h0, 8'h55);
        send_cmd(dhoat_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 8'h0);
        send_cmd(dhoat_pkg::CMD_REMOVE, 32'h55, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h0);

        // tiny table: limit of floor(5*4/5) reached
        write_cfg(dhoat_pkg::CFG_TABLE_SIZE, 5);
        write_cfg(dhoat_pkg::CFG_TOLERANCE, 511);
        for (int j = 0; j < 5; j++) begin
            send_cmd(dhoat_pkg::CMD_INSERT, j, j + 100, 32'h0, 32'h1, 8'h0);
        end
        send_cmd(dhoat_pkg::CMD_REMOVE, 32'd1, 32'h0, 32'h0, 32'h1, 8'h0);
        send_cmd(dhoat_pkg::CMD_INSERT, 32'd9, 32'h9, 32'h0, 32'h1, 8'h0);
        // shrink: entries beyond the size stay readable
        write_cfg(dhoat_pkg::CFG_TABLE_SIZE, 2);
        send_cmd(dhoat_pkg::CMD_READ, 32'h0, 32'h0, 32'h0, 32'h0, 8'd3);
        send_cmd(dhoat_pkg::CMD_LOOKUP, 32'd3, 32'h0, 32'h0, 32'h1, 8'h0);

        // random phases over several settings
        sizes = '{256, 1, 0, 7, 16, 300, 61, 511, 2, 128};
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 50; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            case (ph % 3)
                0: tol = 256 + $urandom_range(255);
                1: tol = (ph == 4) ? 0 : $urandom_range(256);
                default: tol = 256;
            endcase
            write_cfg(dhoat_pkg::CFG_TABLE_SIZE, sizes[ph]);
            write_cfg(dhoat_pkg::CFG_TOLERANCE, tol);
            if (ph == 5) begin
                // sender holds off until the block has answered everything
                random_phase(50, 256);
                wait_drained();
                random_phase(55, 256);
            end else begin
                random_phase(105, (sizes[ph] == 0) ? 1 : (sizes[ph] > 256 ? 256 : sizes[ph]));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
